@@ rtl/core/pnm_pkg.sv @@
// ----------------------------------------------------------------------------
// pnm_pkg: shared types and constants of the binary netpbm stream parser
// Result layout, result kinds, error codes and output buffer sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package pnm_pkg;

    // result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // error codes
    localparam logic [2:0] ERR_BAD_MAGIC  = 3'd0;
    localparam logic [2:0] ERR_NO_WIDTH   = 3'd1;
    localparam logic [2:0] ERR_NO_HEIGHT  = 3'd2;
    localparam logic [2:0] ERR_NO_MAXVAL  = 3'd3;
    localparam logic [2:0] ERR_TOO_LARGE  = 3'd4;
    localparam logic [2:0] ERR_SIZE       = 3'd5;
    localparam logic [2:0] ERR_BAD_DIGIT  = 3'd6;

    // output buffer: room for two results per request plus slack
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] sample_value;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [15:0] max_value;
        logic        color_mode;
        logic        wide_samples;
        logic [2:0]  error_code;
        logic        last_item;
    } t_result;

    // up to two results per request; slot 0 always fills first
    typedef struct packed {
        logic    push0;
        logic    push1;
        t_result res0;
        t_result res1;
    } t_push;

    function automatic t_result make_error(input logic [2:0] code);
        t_result r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        r.last_item  = 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/pnm_stream_if.sv @@
// ----------------------------------------------------------------------------
// pnm_stream_if: byte and result channels of the netpbm parser
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface pnm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface pnm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] sample_value;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [15:0] max_value;
    logic        color_mode;
    logic        wide_samples;
    logic [2:0]  error_code;
    logic        last_item;

    modport source (
        output valid, output kind, output sample_value, output image_width,
        output image_height, output max_value, output color_mode,
        output wide_samples, output error_code, output last_item, input ready
    );
    modport sink (
        input valid, input kind, input sample_value, input image_width,
        input image_height, input max_value, input color_mode,
        input wide_samples, input error_code, input last_item, output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/pnm_binary_stream_parser.sv @@
// ----------------------------------------------------------------------------
// pnm_binary_stream_parser: streaming parser for binary PGM/PPM (P5/P6) files
//
// i_in takes one file byte per request, end_of_file set on the last byte.
// o_out returns results: a header (width, height, maxval, color, sample
// size), then one request per pixel sample (16-bit samples assembled high
// byte first), or an error with a code; errors, the final sample and a header
// ending the file carry last_item. After an error, bytes are swallowed up
// to end_of_file, and the byte carrying end_of_file always returns the
// parser to its start. Results reach o_out through the output buffer.
// Throughput: one byte per cycle while o_out drains one result per cycle;
// a byte can produce two results (a sample or header plus a size error).
// The results pass a four-entry buffer; i_in.ready drops when fewer than
// two entries are free, so a stalled receiver backs up into the byte side
// without losing results.
// Reset (synchronous, active low) clears the parser and empties the buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module pnm_binary_stream_parser #(
    parameter int DIMENSION_BITS = 16
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    pnm_in_if.sink    i_in,
    pnm_out_if.source o_out
);
    import pnm_pkg::*;

    t_push push;
    logic  space_ok;

    // byte-level parse: state update and result generation in the same cycle
    pnm_parse_core #(
        .DIMENSION_BITS (DIMENSION_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_space_ok (space_ok),
        .o_push     (push)
    );

    // result buffer decouples the receiver from the byte stream
    pnm_out_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_space_ok (space_ok),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

@@ rtl/core/pnm_parse_core.sv @@
// ----------------------------------------------------------------------------
// pnm_parse_core: per-byte header/body parser
// Updates parser state on each accepted byte and emits up to two results.
// ----------------------------------------------------------------------------
`default_nettype none

module pnm_parse_core #(
    parameter int DIMENSION_BITS = 16
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    pnm_in_if.sink         i_in,
    input  wire            i_space_ok,
    output pnm_pkg::t_push o_push
);
    import pnm_pkg::*;

    localparam int REM_W = 2 * DIMENSION_BITS + 3;
    localparam logic [19:0] DIM_LIMIT = 20'((64'd1 << DIMENSION_BITS) - 64'd1);
    localparam logic [19:0] MAX_LIMIT = 20'hFFFF;

    localparam logic [2:0] PH_MAGIC0 = 3'd0;
    localparam logic [2:0] PH_MAGIC1 = 3'd1;
    localparam logic [2:0] PH_WIDTH  = 3'd2;
    localparam logic [2:0] PH_HEIGHT = 3'd3;
    localparam logic [2:0] PH_MAXVAL = 3'd4;
    localparam logic [2:0] PH_BODY   = 3'd5;

    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_5    = 8'h35;
    localparam logic [7:0] CH_6    = 8'h36;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LF   = 8'h0A;

    logic [2:0]                  r_phase, n_phase;
    logic                        r_in_comment, n_in_comment;
    logic [15:0]                 r_acc, n_acc;
    logic                        r_saw, n_saw;
    logic [DIMENSION_BITS-1:0]   r_width, n_width;
    logic [DIMENSION_BITS-1:0]   r_height, n_height;
    logic [15:0]                 r_maxval, n_maxval;
    logic                        r_rgb, n_rgb;
    logic                        r_wide, n_wide;
    logic [REM_W-1:0]            r_rem, n_rem;
    logic [7:0]                  r_held, n_held;
    logic                        r_err, n_err;
    logic [2*DIMENSION_BITS-1:0] r_wh;

    logic                        accept;
    logic [7:0]                  b;
    logic                        eof;
    logic [19:0]                 acc_x;
    logic [19:0]                 lim;
    logic [REM_W-1:0]            wh_ext;
    logic [REM_W-1:0]            rem_base;
    logic [REM_W-1:0]            rem_hdr;
    logic [REM_W-1:0]            rem_dec;
    logic                        is_sep;
    logic                        wide_new;
    logic [2:0]                  end_code;
    t_push                       push;

    assign i_in.ready = i_space_ok;
    assign accept     = i_in.valid & i_space_ok;
    assign b          = i_in.data_byte;
    assign eof        = i_in.end_of_file;

    // acc * 10 + digit, digit is the low nibble of an ASCII digit
    assign acc_x  = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1) + {16'd0, b[3:0]};
    assign lim    = (r_phase == PH_MAXVAL) ? MAX_LIMIT : DIM_LIMIT;
    assign is_sep = (b inside {[8'd9:8'd13], 8'd32}) || (b == CH_HASH);

    // body size from the registered width*height product
    assign wide_new = (r_acc > 16'd255);
    assign wh_ext   = REM_W'(r_wh);
    assign rem_base = r_rgb ? (wh_ext + (wh_ext << 1)) : wh_ext;
    assign rem_hdr  = wide_new ? (rem_base << 1) : rem_base;
    assign rem_dec  = r_rem - REM_W'(1);

    always_comb begin
        n_phase      = r_phase;
        n_in_comment = r_in_comment;
        n_acc        = r_acc;
        n_saw        = r_saw;
        n_width      = r_width;
        n_height     = r_height;
        n_maxval     = r_maxval;
        n_rgb        = r_rgb;
        n_wide       = r_wide;
        n_rem        = r_rem;
        n_held       = r_held;
        n_err        = r_err;
        push         = '0;
        end_code     = ERR_BAD_MAGIC;

        if (accept) begin
            if (!r_err) begin
                case (r_phase)
                    PH_MAGIC0: begin
                        if (b == CH_P) begin
                            n_phase = PH_MAGIC1;
                        end else begin
                            n_err      = 1'b1;
                            push.push0 = 1'b1;
                            push.res0  = make_error(ERR_BAD_MAGIC);
                        end
                    end
                    PH_MAGIC1: begin
                        if (b == CH_5 || b == CH_6) begin
                            n_rgb   = (b == CH_6);
                            n_phase = PH_WIDTH;
                        end else begin
                            n_err      = 1'b1;
                            push.push0 = 1'b1;
                            push.res0  = make_error(ERR_BAD_MAGIC);
                        end
                    end
                    PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
                        if (r_in_comment) begin
                            if (b == CH_LF) begin
                                n_in_comment = 1'b0;
                            end
                        end else if (is_sep) begin
                            if (r_saw && r_phase == PH_MAXVAL) begin
                                // separator after maxval: header, then body
                                n_saw                   = 1'b0;
                                n_acc                   = '0;
                                n_maxval                = r_acc;
                                n_wide                  = wide_new;
                                n_rem                   = rem_hdr;
                                n_phase                 = PH_BODY;
                                push.push0              = 1'b1;
                                push.res0.kind          = KIND_HEADER;
                                push.res0.image_width   = 16'(r_width);
                                push.res0.image_height  = 16'(r_height);
                                push.res0.max_value     = r_acc;
                                push.res0.color_mode    = r_rgb;
                                push.res0.wide_samples  = wide_new;
                                push.res0.last_item     = eof && (r_wh == '0);
                                if (eof && r_wh != '0) begin
                                    n_err      = 1'b1;
                                    push.push1 = 1'b1;
                                    push.res1  = make_error(ERR_SIZE);
                                end
                            end else begin
                                if (r_saw) begin
                                    n_saw = 1'b0;
                                    n_acc = '0;
                                    if (r_phase == PH_WIDTH) begin
                                        n_width = r_acc[DIMENSION_BITS-1:0];
                                        n_phase = PH_HEIGHT;
                                    end else begin
                                        n_height = r_acc[DIMENSION_BITS-1:0];
                                        n_phase  = PH_MAXVAL;
                                    end
                                end
                                if (b == CH_HASH) begin
                                    n_in_comment = 1'b1;
                                end
                            end
                        end else if (b inside {[8'h30:8'h39]}) begin
                            n_acc = acc_x[15:0];
                            n_saw = 1'b1;
                            if (acc_x > lim) begin
                                n_err      = 1'b1;
                                push.push0 = 1'b1;
                                push.res0  = make_error(ERR_TOO_LARGE);
                            end
                        end else begin
                            n_err      = 1'b1;
                            push.push0 = 1'b1;
                            push.res0  = make_error(ERR_BAD_DIGIT);
                        end
                    end
                    PH_BODY: begin
                        if (r_rem == '0) begin
                            n_err      = 1'b1;
                            push.push0 = 1'b1;
                            push.res0  = make_error(ERR_SIZE);
                        end else begin
                            n_rem = rem_dec;
                            if (r_wide && !r_rem[0]) begin
                                // high byte of a 16-bit sample
                                n_held = b;
                                if (eof) begin
                                    n_err      = 1'b1;
                                    push.push0 = 1'b1;
                                    push.res0  = make_error(ERR_SIZE);
                                end
                            end else begin
                                push.push0              = 1'b1;
                                push.res0.kind          = KIND_SAMPLE;
                                push.res0.sample_value  = r_wide ? {r_held, b} : {8'd0, b};
                                push.res0.last_item     = eof && (rem_dec == '0);
                                if (eof && rem_dec != '0) begin
                                    n_err      = 1'b1;
                                    push.push1 = 1'b1;
                                    push.res1  = make_error(ERR_SIZE);
                                end
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_MAGIC0;
                    end
                endcase

                // file ended inside the header: report the first missing item
                if (eof && !n_err && n_phase < PH_BODY) begin
                    case (n_phase)
                        PH_WIDTH:  end_code = n_saw ? ERR_NO_HEIGHT : ERR_NO_WIDTH;
                        PH_HEIGHT: end_code = n_saw ? ERR_NO_MAXVAL : ERR_NO_HEIGHT;
                        PH_MAXVAL: end_code = n_saw ? ERR_SIZE : ERR_NO_MAXVAL;
                        default:   end_code = ERR_BAD_MAGIC;
                    endcase
                    push.push0 = 1'b1;
                    push.res0  = make_error(end_code);
                end
            end

            if (eof) begin
                n_phase      = PH_MAGIC0;
                n_in_comment = 1'b0;
                n_acc        = '0;
                n_saw        = 1'b0;
                n_width      = '0;
                n_height     = '0;
                n_maxval     = '0;
                n_rgb        = 1'b0;
                n_wide       = 1'b0;
                n_rem        = '0;
                n_held       = '0;
                n_err        = 1'b0;
            end
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_MAGIC0;
            r_in_comment <= 1'b0;
            r_acc        <= '0;
            r_saw        <= 1'b0;
            r_width      <= '0;
            r_height     <= '0;
            r_maxval     <= '0;
            r_rgb        <= 1'b0;
            r_wide       <= 1'b0;
            r_rem        <= '0;
            r_held       <= '0;
            r_err        <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_in_comment <= n_in_comment;
            r_acc        <= n_acc;
            r_saw        <= n_saw;
            r_width      <= n_width;
            r_height     <= n_height;
            r_maxval     <= n_maxval;
            r_rgb        <= n_rgb;
            r_wide       <= n_wide;
            r_rem        <= n_rem;
            r_held       <= n_held;
            r_err        <= n_err;
        end
    end

    // width*height, registered from r_width and r_height; it settles at least
    // one request ahead of the earliest maxval separator
    always_ff @(posedge i_clk) begin
        r_wh <= r_width * r_height;
    end

endmodule

`default_nettype wire

@@ rtl/core/pnm_out_fifo.sv @@
// ----------------------------------------------------------------------------
// pnm_out_fifo: result buffer
// Takes up to two results per cycle and presents them one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module pnm_out_fifo (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  pnm_pkg::t_push i_push,
    output logic           o_space_ok,
    pnm_out_if.source      o_out
);
    import pnm_pkg::*;

    t_result                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wp;
    logic [FIFO_PTR_W-1:0]  r_rp;
    logic [FIFO_CNT_W-1:0]  r_count, n_count;
    logic                   pop;
    logic [FIFO_CNT_W-1:0]  n_push;
    t_result                head;

    assign n_push  = FIFO_CNT_W'(i_push.push0) + FIFO_CNT_W'(i_push.push1);
    assign pop     = o_out.valid & o_out.ready;
    assign n_count = r_count + n_push - FIFO_CNT_W'(pop);

    // room for a full pair of results
    assign o_space_ok = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wp] <= i_push.res0;
        end
        if (i_push.push1) begin
            r_mem[r_wp + FIFO_PTR_W'(1)] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + n_push[FIFO_PTR_W-1:0];
            r_rp    <= r_rp + FIFO_PTR_W'(pop);
            r_count <= n_count;
        end
    end

    assign head               = r_mem[r_rp];
    assign o_out.valid        = (r_count != '0);
    assign o_out.kind         = head.kind;
    assign o_out.sample_value = head.sample_value;
    assign o_out.image_width  = head.image_width;
    assign o_out.image_height = head.image_height;
    assign o_out.max_value    = head.max_value;
    assign o_out.color_mode   = head.color_mode;
    assign o_out.wide_samples = head.wide_samples;
    assign o_out.error_code   = head.error_code;
    assign o_out.last_item    = head.last_item;

endmodule

`default_nettype wire

@@ verif/tb_pnm_binary_stream_parser.sv @@
// ----------------------------------------------------------------------------
// tb_pnm_binary_stream_parser: self-checking bench for the netpbm byte parser
// Feeds P5/P6 files byte by byte with random gaps and result-side stalls,
// tracks the parser state in a local byte scanner and compares every result
// field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_pnm_binary_stream_parser;
    import pnm_pkg::*;

    localparam int          DIMENSION_BITS  = 16;
    localparam int unsigned DIMENSION_LIMIT = (1 << DIMENSION_BITS) - 1;
    localparam int unsigned MAXVAL_LIMIT    = 65535;
    localparam int          RANDOM_BYTES    = 1900;

    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_HASH  = 8'h23;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_FIVE  = 8'h35;
    localparam logic [7:0] CHR_SIX   = 8'h36;
    localparam logic [7:0] CHR_P     = 8'h50;

    typedef enum logic [2:0] {
        SCAN_MAGIC_P,
        SCAN_MAGIC_DIGIT,
        SCAN_WIDTH,
        SCAN_HEIGHT,
        SCAN_MAXVAL,
        SCAN_BODY
    } t_scan_phase;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pnm_in_if  in_ch ();
    pnm_out_if out_ch ();

    pnm_binary_stream_parser #(
        .DIMENSION_BITS(DIMENSION_BITS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // scanner state, mirrors the parser
    t_scan_phase       scan_phase;
    bit                in_comment;
    int unsigned       number_acc;
    bit                number_seen;
    logic [15:0]       hdr_width;
    logic [15:0]       hdr_height;
    logic [15:0]       hdr_maxval;
    bit                hdr_rgb;
    bit                hdr_wide;
    longint unsigned   body_left;
    logic [7:0]        high_byte;
    bit                fault;

    t_result    parser_results_due[$];
    logic [7:0] file_image[$];
    int         mismatch_count = 0;
    int         parsed_bytes   = 0;
    bit         flow_steady    = 1'b0;
    int         stall_left     = 0;

    function automatic void clear_scanner();
        scan_phase  = SCAN_MAGIC_P;
        in_comment  = 1'b0;
        number_acc  = 0;
        number_seen = 1'b0;
        hdr_width   = '0;
        hdr_height  = '0;
        hdr_maxval  = '0;
        hdr_rgb     = 1'b0;
        hdr_wide    = 1'b0;
        body_left   = 0;
        high_byte   = '0;
        fault       = 1'b0;
    endfunction

    function automatic void expect_item(logic [1:0] kind, logic [15:0] sample, bit with_hdr,
                                        logic [2:0] code, bit last);
        t_result r;
        r              = '0;
        r.kind         = kind;
        r.sample_value = sample;
        if (with_hdr) begin
            r.image_width  = hdr_width;
            r.image_height = hdr_height;
            r.max_value    = hdr_maxval;
            r.color_mode   = hdr_rgb;
            r.wide_samples = hdr_wide;
        end
        r.error_code = code;
        r.last_item  = last;
        parser_results_due.push_back(r);
    endfunction

    function automatic void expect_fault(logic [2:0] code);
        fault = 1'b1;
        expect_item(KIND_ERROR, '0, 1'b0, code, 1'b1);
    endfunction

    function automatic bit is_blank(logic [7:0] b);
        return b == CHR_SPACE || (b >= CHR_TAB && b <= CHR_CR);
    endfunction

    // width, height and maxval phases
    function automatic void scan_number_byte(logic [7:0] b, bit eof);
        int unsigned value;
        int unsigned limit;
        if (in_comment) begin
            if (b == CHR_LF)
                in_comment = 1'b0;
            return;
        end
        if (is_blank(b) || b == CHR_HASH) begin
            if (number_seen) begin
                value       = number_acc;
                number_seen = 1'b0;
                number_acc  = 0;
                case (scan_phase)
                    SCAN_WIDTH: begin
                        hdr_width  = value[15:0];
                        scan_phase = SCAN_HEIGHT;
                    end
                    SCAN_HEIGHT: begin
                        hdr_height = value[15:0];
                        scan_phase = SCAN_MAXVAL;
                    end
                    default: begin
                        // terminator of maxval is the dropped separator
                        hdr_maxval = value[15:0];
                        hdr_wide   = value > 255;
                        body_left  = longint'(hdr_width) * longint'(hdr_height)
                                   * (hdr_rgb ? 3 : 1) * (hdr_wide ? 2 : 1);
                        scan_phase = SCAN_BODY;
                        expect_item(KIND_HEADER, '0, 1'b1, '0, eof && body_left == 0);
                        if (eof && body_left != 0)
                            expect_fault(ERR_SIZE);
                        return;
                    end
                endcase
            end
            if (b == CHR_HASH)
                in_comment = 1'b1;
            return;
        end
        if (b >= CHR_ZERO && b <= CHR_NINE) begin
            limit       = (scan_phase == SCAN_MAXVAL) ? MAXVAL_LIMIT : DIMENSION_LIMIT;
            number_acc  = number_acc * 10 + (b - CHR_ZERO);
            number_seen = 1'b1;
            if (number_acc > limit)
                expect_fault(ERR_TOO_LARGE);
            return;
        end
        expect_fault(ERR_BAD_DIGIT);
    endfunction

    function automatic void scan_file_byte(logic [7:0] b, bit eof);
        bit upper;
        if (!fault) begin
            case (scan_phase)
                SCAN_MAGIC_P: begin
                    if (b == CHR_P)
                        scan_phase = SCAN_MAGIC_DIGIT;
                    else
                        expect_fault(ERR_BAD_MAGIC);
                end
                SCAN_MAGIC_DIGIT: begin
                    if (b == CHR_FIVE || b == CHR_SIX) begin
                        hdr_rgb    = (b == CHR_SIX);
                        scan_phase = SCAN_WIDTH;
                    end else begin
                        expect_fault(ERR_BAD_MAGIC);
                    end
                end
                SCAN_BODY: begin
                    if (body_left == 0) begin
                        expect_fault(ERR_SIZE);
                    end else begin
                        upper = hdr_wide && !body_left[0];
                        body_left--;
                        if (upper)
                            high_byte = b;
                        else
                            expect_item(KIND_SAMPLE, hdr_wide ? {high_byte, b} : {8'h00, b},
                                        1'b0, '0, eof && body_left == 0);
                        if (eof && body_left != 0)
                            expect_fault(ERR_SIZE);
                    end
                end
                default: scan_number_byte(b, eof);
            endcase
            // file ended before the header was complete
            if (eof && !fault && scan_phase != SCAN_BODY) begin
                case (scan_phase)
                    SCAN_WIDTH:  expect_fault(number_seen ? ERR_NO_HEIGHT : ERR_NO_WIDTH);
                    SCAN_HEIGHT: expect_fault(number_seen ? ERR_NO_MAXVAL : ERR_NO_HEIGHT);
                    SCAN_MAXVAL: expect_fault(number_seen ? ERR_SIZE : ERR_NO_MAXVAL);
                    default:     expect_fault(ERR_BAD_MAGIC);
                endcase
            end
        end
        if (eof)
            clear_scanner();
    endfunction

    // mostly no gap, otherwise short gaps and a few long ones
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (flow_steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_byte(logic [7:0] b, bit eof);
        int gap;
        gap = pick_pause();
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid       <= 1'b1;
        in_ch.data_byte   <= b;
        in_ch.end_of_file <= eof;
        do @(posedge i_clk); while (!in_ch.ready);
        if (!fault)
            parsed_bytes++;
        scan_file_byte(b, eof);
    endtask

    task automatic send_file();
        foreach (file_image[i])
            send_byte(file_image[i], i == file_image.size() - 1);
    endtask

    function automatic void load_text(string s);
        foreach (s[i])
            file_image.push_back(s[i]);
    endfunction

    function automatic void add_number(int unsigned v);
        if ($urandom_range(0, 5) == 0)
            file_image.push_back(CHR_ZERO);
        load_text($sformatf("%0d", v));
    endfunction

    function automatic logic [7:0] pick_blank();
        int r;
        r = $urandom_range(9, 14);
        return (r == 14) ? CHR_SPACE : r[7:0];
    endfunction

    // blanks and comments between header tokens
    function automatic void add_gap(bit needed);
        int count;
        int n;
        logic [7:0] c;
        count = needed ? $urandom_range(1, 2) : $urandom_range(0, 2);
        repeat (count) begin
            if ($urandom_range(0, 3) == 0) begin
                file_image.push_back(CHR_HASH);
                n = $urandom_range(0, 4);
                repeat (n) begin
                    c = 8'($urandom_range(0, 255));
                    file_image.push_back(c == CHR_LF ? CHR_SPACE : c);
                end
                file_image.push_back(CHR_LF);
            end else begin
                file_image.push_back(pick_blank());
            end
        end
    endfunction

    function automatic void build_image(bit oversize);
        int unsigned w;
        int unsigned h;
        int unsigned m;
        int unsigned n;
        bit color;
        file_image.delete();
        color = 1'($urandom_range(0, 1));
        file_image.push_back(CHR_P);
        file_image.push_back(color ? CHR_SIX : CHR_FIVE);
        // a large dimension only with an empty body
        case ($urandom_range(0, 9))
            0: begin
                w = $urandom_range(0, 65535);
                h = 0;
            end
            1: begin
                w = 0;
                h = $urandom_range(0, 65535);
            end
            default: begin
                w = $urandom_range(0, 3);
                h = $urandom_range(0, 3);
            end
        endcase
        case ($urandom_range(0, 9))
            0:       m = 0;
            1:       m = 255;
            2:       m = 256;
            3:       m = 65535;
            4, 5, 6: m = $urandom_range(1, 255);
            default: m = $urandom_range(256, 65535);
        endcase
        if (oversize) begin
            case ($urandom_range(0, 2))
                0:       w = $urandom_range(65536, 999999);
                1:       h = $urandom_range(65536, 999999);
                default: m = $urandom_range(65536, 999999);
            endcase
        end
        add_gap(1'b0);
        add_number(w);
        add_gap(1'b1);
        add_number(h);
        add_gap(1'b1);
        add_number(m);
        file_image.push_back($urandom_range(0, 5) == 0 ? CHR_HASH : pick_blank());
        if (!oversize) begin
            n = w * h * (color ? 3 : 1) * (m > 255 ? 2 : 1);
            repeat (n) file_image.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // result side: random stalls
    always @(negedge i_clk) begin
        int len;
        if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else begin
            len = pick_pause();
            if (len > 0) begin
                stall_left = len - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (parser_results_due.size() == 0) begin
                $error("result with none outstanding: kind %0d code %0d",
                       out_ch.kind, out_ch.error_code);
                mismatch_count++;
            end else begin
                want = parser_results_due.pop_front();
                check_field("kind", 16'(want.kind), 16'(out_ch.kind));
                check_field("sample_value", want.sample_value, out_ch.sample_value);
                check_field("image_width", want.image_width, out_ch.image_width);
                check_field("image_height", want.image_height, out_ch.image_height);
                check_field("max_value", want.max_value, out_ch.max_value);
                check_field("color_mode", 16'(want.color_mode), 16'(out_ch.color_mode));
                check_field("wide_samples", 16'(want.wide_samples),
                            16'(out_ch.wide_samples));
                check_field("error_code", 16'(want.error_code), 16'(out_ch.error_code));
                check_field("last_item", 16'(want.last_item), 16'(out_ch.last_item));
            end
        end
    end

    // 16-bit RGB at full maxval, comment after the magic, extreme samples
    task automatic test_wide_rgb_image();
        file_image.delete();
        load_text("P6#c\n1 1 65535\t");
        file_image.push_back(8'hFF);
        file_image.push_back(8'hFF);
        file_image.push_back(8'h00);
        file_image.push_back(8'h00);
        file_image.push_back(8'h80);
        file_image.push_back(8'h01);
        send_file();
    endtask

    // zero-sized body, file ends on the separator: header is the last item
    task automatic test_empty_image();
        file_image.delete();
        load_text("P50 0 0 ");
        send_file();
    endtask

    task automatic test_bad_magic();
        file_image.delete();
        load_text("Q");
        send_file();
    endtask

    // stray byte inside the width; no end-of-file error behind it
    task automatic test_bad_digit();
        file_image.delete();
        load_text("P5x");
        send_file();
    endtask

    // mostly well-formed files, the rest broken or noise
    task automatic test_random_files();
        int r;
        int n;
        int start;
        start = parsed_bytes;
        while (parsed_bytes - start < RANDOM_BYTES) begin
            flow_steady = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            build_image(r >= 94);
            if (r >= 70 && r < 78) begin
                repeat ($urandom_range(1, 3))
                    file_image.push_back(8'($urandom_range(0, 255)));
            end else if (r >= 78 && r < 86) begin
                n = $urandom_range(1, file_image.size());
                while (file_image.size() > n)
                    void'(file_image.pop_back());
            end else if (r >= 86 && r < 90) begin
                file_image[$urandom_range(0, file_image.size() - 1)] =
                    8'($urandom_range(0, 255));
            end else if (r >= 90 && r < 94) begin
                file_image.delete();
                repeat ($urandom_range(1, 6))
                    file_image.push_back(8'($urandom_range(0, 255)));
            end
            send_file();
        end
        flow_steady = 1'b0;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.data_byte   = '0;
        in_ch.end_of_file = 1'b0;
        out_ch.ready      = 1'b0;
        clear_scanner();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_wide_rgb_image();
        test_empty_image();
        test_bad_magic();
        test_bad_digit();
        test_random_files();

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (parser_results_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
